// ===== rtl/bgzf_pkg.sv =====
// ----------------------------------------------------------------------------
// bgzf_pkg
// Shared types and constants for the BGZF block deframer: the event passed
// from the parser to the batch stage, the result beat, and the queue sizing.
// ----------------------------------------------------------------------------
package bgzf_pkg;

  // Result kinds, also used as event kinds in the parser-to-batch queue
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DESC    = 2'd1,
    KIND_FLUSH   = 2'd2
  } kind_t;

  // Batch size register
  localparam int          BATCH_W          = 17;
  localparam logic [16:0] BATCH_RESET      = 17'd512;
  localparam logic [16:0] MAX_BATCH_BLOCKS = 17'd65536;

  // Parser-to-batch queue
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  // One classified event from the parser
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;   // payload byte
    logic [15:0] csize;       // compressed payload length of the block
    logic [31:0] isize;       // ISIZE from the footer
  } evt_t;

  // One result beat
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] compressed_size;
    logic [31:0] uncomp_size;
    logic [47:0] out_offset;
    logic [47:0] batch_total;
    logic        batch_done;
    logic [16:0] batch_count;
  } rslt_t;

endpackage

// ===== rtl/bgzf_block_deframer_core.sv =====
// ----------------------------------------------------------------------------
// bgzf_block_deframer_core
// BGZF block deframer: takes a BGZF file one byte per beat, passes out the
// compressed payload bytes and emits one descriptor per block (compressed
// size, ISIZE, offset within the batch); batches close after a programmable
// block count or on a flush beat. One input beat is accepted per clock while
// in_tready is high; results go through the four-entry event queue and the
// output register. The queue sits between the byte parser and the batch
// stage, so in_tready drops only once four events (result beats or flushes)
// wait behind a stalled output beat. Header magic and CRC are not checked.
// ----------------------------------------------------------------------------
module bgzf_block_deframer_core
  import bgzf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,    // [7:0] data_byte
  input  logic [0:0]         in_tuser,    // [0] opcode (1 = end-of-file flush)
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  // [7:0] payload_byte, [23:8] compressed_size, [55:24] uncomp_size,
  // [103:56] out_offset, [151:104] batch_total, [168:152] batch_count, zero pad
  output logic [175:0]       out_tdata,
  output logic [1:0]         out_tuser,   // [1:0] kind
  output logic               out_tlast,   // batch_done
  // batch size register
  input  logic               cfg_we,
  input  logic [BATCH_W-1:0] cfg_wdata
);

  logic [BATCH_W-1:0] batch_blocks_r;
  logic [BATCH_W-1:0] eff_batch;
  logic               q_full;
  logic               q_nonempty;
  logic               q_pop;
  logic               evt_push;
  evt_t               evt;
  evt_t               q_head;
  rslt_t              beat;

  // Batch size register; the effective batch size is clamped to 1..MAX_BATCH_BLOCKS
  always_ff @(posedge clk) begin
    if (!rst_n) batch_blocks_r <= BATCH_RESET;
    else if (cfg_we) batch_blocks_r <= cfg_wdata;
  end

  always_comb begin
    if (batch_blocks_r == '0) eff_batch = BATCH_W'(1);
    else if (batch_blocks_r > MAX_BATCH_BLOCKS) eff_batch = MAX_BATCH_BLOCKS;
    else eff_batch = batch_blocks_r;
  end

  bgzf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .opcode    (in_tuser[0]),
    .data_byte (in_tdata),
    .q_full    (q_full),
    .evt_push  (evt_push),
    .evt       (evt)
  );

  bgzf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt_push),
    .push_data (evt),
    .pop       (q_pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  bgzf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_batch  (eff_batch),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_beat   (beat)
  );

  // Result beat packing
  assign out_tdata = {7'd0, beat.batch_count, beat.batch_total, beat.out_offset,
                      beat.uncomp_size, beat.compressed_size, beat.payload_byte};
  assign out_tuser = beat.kind;
  assign out_tlast = beat.batch_done;

endmodule

// ===== rtl/bgzf_front.sv =====
// ----------------------------------------------------------------------------
// bgzf_front
// Byte parser: walks the gzip header, the extra subfields (capturing BSIZE),
// the compressed payload and the footer, and pushes one event per byte that
// produces something (payload byte, block descriptor, flush).
// ----------------------------------------------------------------------------
module bgzf_front
  import bgzf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       opcode,
  input  logic [7:0] data_byte,
  input  logic       q_full,
  output logic       evt_push,
  output evt_t       evt
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_EXTRA,
    PH_PAYLOAD,
    PH_FOOTER
  } phase_t;

  localparam logic [3:0]  HDR_XLEN_LO = 4'd10;
  localparam logic [3:0]  HDR_XLEN_HI = 4'd11;
  localparam logic [3:0]  EXT_SI1     = 4'd0;
  localparam logic [3:0]  EXT_SI2     = 4'd1;
  localparam logic [3:0]  EXT_SLEN_LO = 4'd2;
  localparam logic [3:0]  EXT_SLEN_HI = 4'd3;
  localparam logic [3:0]  EXT_DATA    = 4'd4;
  localparam logic [3:0]  FTR_LAST    = 4'd7;
  localparam logic [7:0]  BC_SI1      = 8'd66;
  localparam logic [7:0]  BC_SI2      = 8'd67;
  localparam logic [15:0] BC_SLEN     = 16'd2;
  localparam logic [15:0] HDR_BIAS    = 16'd19;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] xlen_r, xlen_nxt;
  logic [15:0] xleft_r, xleft_nxt;
  logic [7:0]  si1_r, si1_nxt;
  logic [7:0]  si2_r, si2_nxt;
  logic [15:0] slen_r, slen_nxt;
  logic [15:0] bsize_r, bsize_nxt;
  logic [15:0] pleft_r, pleft_nxt;
  logic [15:0] csize_r, csize_nxt;
  logic [31:0] isize_r, isize_nxt;
  logic        accept;
  logic        enter;
  logic [15:0] psize;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // Next-state logic for one accepted beat
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    xlen_nxt  = xlen_r;
    xleft_nxt = xleft_r;
    si1_nxt   = si1_r;
    si2_nxt   = si2_r;
    slen_nxt  = slen_r;
    bsize_nxt = bsize_r;
    pleft_nxt = pleft_r;
    csize_nxt = csize_r;
    isize_nxt = isize_r;
    enter     = 1'b0;
    psize     = '0;
    evt_push  = 1'b0;
    evt.kind      = KIND_PAYLOAD;
    evt.data_byte = data_byte;
    evt.csize     = csize_r;
    evt.isize     = {data_byte, isize_r[23:0]};

    if (accept) begin
      if (opcode) begin
        // flush: drop any partial block, batch stage decides on a result
        phase_nxt = PH_HEADER;
        idx_nxt   = '0;
        evt_push  = 1'b1;
        evt.kind  = KIND_FLUSH;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (idx_r == '0) bsize_nxt = '0;
            if (idx_r == HDR_XLEN_LO) xlen_nxt = {8'd0, data_byte};
            if (idx_r >= HDR_XLEN_HI) begin
              xlen_nxt  = {data_byte, xlen_r[7:0]};
              xleft_nxt = xlen_nxt;
              idx_nxt   = '0;
              si1_nxt   = '0;
              si2_nxt   = '0;
              slen_nxt  = '0;
              if (xlen_nxt == '0) enter = 1'b1;
              else phase_nxt = PH_EXTRA;
            end else begin
              idx_nxt = idx_r + 4'd1;
            end
          end
          PH_EXTRA: begin
            // subfield walk: SI1, SI2, SLEN (LE), then SLEN data bytes
            case (idx_r)
              EXT_SI1: begin
                si1_nxt = data_byte;
                idx_nxt = EXT_SI2;
              end
              EXT_SI2: begin
                si2_nxt = data_byte;
                idx_nxt = EXT_SLEN_LO;
              end
              EXT_SLEN_LO: begin
                slen_nxt = {8'd0, data_byte};
                idx_nxt  = EXT_SLEN_HI;
              end
              EXT_SLEN_HI: begin
                slen_nxt = {data_byte, slen_r[7:0]};
                if (!(si1_r == BC_SI1 && si2_r == BC_SI2 && slen_nxt == BC_SLEN))
                  si1_nxt = '0;
                idx_nxt = (slen_nxt == '0) ? EXT_SI1 : EXT_DATA;
              end
              default: begin
                if (si1_r == BC_SI1) begin
                  if (slen_r == BC_SLEN) bsize_nxt = {8'd0, data_byte};
                  else bsize_nxt = bsize_r | {data_byte, 8'd0};
                end
                slen_nxt = slen_r - 16'd1;
                if (slen_nxt == '0) idx_nxt = EXT_SI1;
              end
            endcase
            xleft_nxt = xleft_r - 16'd1;
            if (xleft_nxt == '0) enter = 1'b1;
          end
          PH_PAYLOAD: begin
            evt_push  = 1'b1;
            evt.kind  = KIND_PAYLOAD;
            pleft_nxt = pleft_r - 16'd1;
            if (pleft_nxt == '0) begin
              phase_nxt = PH_FOOTER;
              idx_nxt   = '0;
            end
          end
          PH_FOOTER: begin
            // CRC32 bytes are skipped, ISIZE bytes collected little-endian
            if (idx_r[2]) isize_nxt[8*idx_r[1:0] +: 8] = data_byte;
            if (idx_r < FTR_LAST) begin
              idx_nxt = idx_r + 4'd1;
            end else begin
              evt_push  = 1'b1;
              evt.kind  = KIND_DESC;
              phase_nxt = PH_HEADER;
              idx_nxt   = '0;
            end
          end
          default: phase_nxt = PH_HEADER;
        endcase

        // start of payload: length is BSIZE - XLEN - 19, wrapped
        if (enter) begin
          psize     = bsize_nxt - xlen_nxt - HDR_BIAS;
          pleft_nxt = psize;
          csize_nxt = psize;
          idx_nxt   = '0;
          phase_nxt = (psize == '0) ? PH_FOOTER : PH_PAYLOAD;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      idx_r   <= '0;
      xlen_r  <= '0;
      xleft_r <= '0;
      si1_r   <= '0;
      si2_r   <= '0;
      slen_r  <= '0;
      bsize_r <= '0;
      pleft_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      xlen_r  <= xlen_nxt;
      xleft_r <= xleft_nxt;
      si1_r   <= si1_nxt;
      si2_r   <= si2_nxt;
      slen_r  <= slen_nxt;
      bsize_r <= bsize_nxt;
      pleft_r <= pleft_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    csize_r <= csize_nxt;
    isize_r <= isize_nxt;
  end

endmodule

// ===== rtl/bgzf_queue.sv =====
// ----------------------------------------------------------------------------
// bgzf_queue
// Small event queue between the parser and the batch stage so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module bgzf_queue
  import bgzf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  evt_t push_data,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output evt_t head
);

  evt_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/bgzf_back.sv =====
// ----------------------------------------------------------------------------
// bgzf_back
// Batch stage: takes events from the queue, keeps the block count and the
// uncompressed offset of the current batch, and drives the output register.
// ----------------------------------------------------------------------------
module bgzf_back
  import bgzf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [BATCH_W-1:0] eff_batch,
  input  logic               q_nonempty,
  input  evt_t               q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output rslt_t              out_beat
);

  logic [BATCH_W-1:0] bib_r, bib_nxt;
  logic [47:0]        boff_r, boff_nxt;
  logic               vld_r, vld_nxt;
  rslt_t              beat_r, beat_nxt;
  logic [BATCH_W-1:0] bib_inc;
  logic [47:0]        total;

  assign out_valid = vld_r;
  assign out_beat  = beat_r;
  assign q_pop     = q_nonempty && (!vld_r || out_ready);
  assign bib_inc   = bib_r + 1'b1;
  assign total     = boff_r + {16'd0, q_head.isize};

  // Batch accounting and result formation
  always_comb begin
    bib_nxt  = bib_r;
    boff_nxt = boff_r;
    vld_nxt  = vld_r && !out_ready;
    beat_nxt = beat_r;
    if (q_pop) begin
      beat_nxt      = '0;
      beat_nxt.kind = q_head.kind;
      vld_nxt       = 1'b1;
      unique case (q_head.kind)
        KIND_PAYLOAD: begin
          beat_nxt.payload_byte    = q_head.data_byte;
          beat_nxt.compressed_size = q_head.csize;
        end
        KIND_DESC: begin
          beat_nxt.compressed_size = q_head.csize;
          beat_nxt.uncomp_size     = q_head.isize;
          beat_nxt.out_offset      = boff_r;
          beat_nxt.batch_total     = total;
          beat_nxt.batch_count     = bib_inc;
          if (bib_inc >= eff_batch) begin
            beat_nxt.batch_done = 1'b1;
            bib_nxt             = '0;
            boff_nxt            = '0;
          end else begin
            bib_nxt  = bib_inc;
            boff_nxt = total;
          end
        end
        KIND_FLUSH: begin
          // an empty batch flushes silently
          if (bib_r == '0) begin
            vld_nxt = 1'b0;
          end else begin
            beat_nxt.batch_total = boff_r;
            beat_nxt.batch_done  = 1'b1;
            beat_nxt.batch_count = bib_r;
            bib_nxt              = '0;
            boff_nxt             = '0;
          end
        end
        default: vld_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bib_r  <= '0;
      boff_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      bib_r  <= bib_nxt;
      boff_r <= boff_nxt;
      vld_r  <= vld_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bgzf_block_deframer_core. BGZF blocks are built from
// randomized subfield layouts (valid, decoy, repeated and truncated BSIZE
// fields), mixed with cut-off blocks, wrapped payload sizes, junk bytes and
// flushes, and pushed through the input stream with random gaps. Every
// accepted beat runs through a bit-accurate parser model that queues the
// expected result beats, and the output monitor checks each result beat
// field by field. The batch size register is reprogrammed between phases.
// ----------------------------------------------------------------------------
module testbench;
  import bgzf_pkg::*;

  localparam int          RESET_CYCLES  = 7;
  localparam int          SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int          PHASE_BEATS   = 60;
  localparam int          MAX_REPORTS   = 30;

  // input opcodes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // gzip / BGZF framing constants
  localparam logic [7:0]  GZ_ID1        = 8'd31;
  localparam logic [7:0]  GZ_ID2        = 8'd139;
  localparam logic [7:0]  GZ_CM_DEFLATE = 8'd8;
  localparam logic [7:0]  GZ_FLG_EXTRA  = 8'd4;
  localparam logic [7:0]  BSIZE_ID1     = 8'd66;
  localparam logic [7:0]  BSIZE_ID2     = 8'd67;
  localparam logic [15:0] BSIZE_SLEN    = 16'd2;
  localparam logic [15:0] BSIZE_BIAS    = 16'd19;
  localparam int          HDR_BYTES     = 12;
  localparam int          XLEN_LO_AT    = 10;
  localparam int          XLEN_HI_AT    = 11;
  localparam int          FOOTER_LAST   = 7;

  // block shapes produced by the stimulus generator
  localparam int MODE_GOOD      = 0;  // proper block, BSIZE matches the payload
  localparam int MODE_CUT_OTHER = 1;  // trailing subfield truncated by XLEN
  localparam int MODE_CUT_LOW   = 2;  // BSIZE truncated after its low byte
  localparam int MODE_NO_BSIZE  = 3;  // no BSIZE subfield, payload size wraps
  localparam int MODE_WRAP      = 4;  // BSIZE too small, payload size wraps
  localparam int MODE_WRAP_MAX  = 5;  // payload size wraps to all ones

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_EXTRA,
    PH_PAYLOAD,
    PH_FOOTER
  } parse_phase_t;

  // --------------------------------------------------------------------------
  // Parser model and pending result store
  // --------------------------------------------------------------------------
  class deframe_tracker;
    logic [16:0]  blocks_per_batch;
    parse_phase_t ph;
    logic [15:0]  idx, xlen, xleft, slen, bsize, pleft;
    logic [7:0]   id1, id2;
    logic [63:0]  fshift;
    logic [16:0]  nblk;
    logic [47:0]  boff;
    rslt_t        awaited[$];
    int           errors;
    int           nres;

    function new();
      blocks_per_batch = BATCH_RESET;
      ph     = PH_HEADER;
      idx    = '0;
      xlen   = '0;
      xleft  = '0;
      slen   = '0;
      bsize  = '0;
      pleft  = '0;
      id1    = '0;
      id2    = '0;
      fshift = '0;
      nblk   = '0;
      boff   = '0;
      errors = 0;
      nres   = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t: deframer mismatch: %s", $time, msg);
    endfunction

    function logic [15:0] pay_len();
      return bsize - xlen - BSIZE_BIAS;
    endfunction

    function logic [16:0] batch_limit();
      logic [16:0] b;
      b = blocks_per_batch;
      if (b == '0) b = 17'd1;
      if (b > MAX_BATCH_BLOCKS) b = MAX_BATCH_BLOCKS;
      return b;
    endfunction

    function void enter_payload();
      pleft  = pay_len();
      fshift = '0;
      idx    = '0;
      ph     = (pleft == '0) ? PH_FOOTER : PH_PAYLOAD;
    endfunction

    // one byte of the extra field: subfield id, length, then data
    function void extra_byte(logic [7:0] v);
      case (idx)
        16'd0: begin
          id1 = v;
          idx = 16'd1;
        end
        16'd1: begin
          id2 = v;
          idx = 16'd2;
        end
        16'd2: begin
          slen = {8'h00, v};
          idx  = 16'd3;
        end
        16'd3: begin
          slen = slen | {v, 8'h00};
          if (!(id1 == BSIZE_ID1 && id2 == BSIZE_ID2 && slen == BSIZE_SLEN)) id1 = '0;
          idx = (slen == '0) ? 16'd0 : 16'd4;
        end
        default: begin
          if (id1 == BSIZE_ID1) begin
            if (slen == BSIZE_SLEN) bsize = {8'h00, v};
            else bsize = bsize | {v, 8'h00};
          end
          slen = slen - 16'd1;
          if (slen == '0) idx = '0;
        end
      endcase
      xleft = xleft - 16'd1;
      if (xleft == '0) enter_payload();
    endfunction

    // accepted input beat: advance the parser, queue any result it causes
    function void accept_item(logic op, logic [7:0] v);
      rslt_t r;
      r = '0;
      if (op == OP_FLUSH) begin
        ph  = PH_HEADER;
        idx = '0;
        if (nblk != '0) begin
          r.kind        = KIND_FLUSH;
          r.batch_total = boff;
          r.batch_done  = 1'b1;
          r.batch_count = nblk;
          awaited.push_back(r);
          nblk = '0;
          boff = '0;
        end
        return;
      end
      case (ph)
        PH_HEADER: begin
          if (idx == 16'd0) bsize = '0;
          if (idx == XLEN_LO_AT) xlen = {8'h00, v};
          if (idx == XLEN_HI_AT) xlen = xlen | {v, 8'h00};
          if (idx >= XLEN_HI_AT) begin
            xleft = xlen;
            idx   = '0;
            id1   = '0;
            id2   = '0;
            slen  = '0;
            if (xlen == '0) enter_payload();
            else ph = PH_EXTRA;
          end else begin
            idx++;
          end
        end
        PH_EXTRA: extra_byte(v);
        PH_PAYLOAD: begin
          r.kind            = KIND_PAYLOAD;
          r.payload_byte    = v;
          r.compressed_size = pay_len();
          awaited.push_back(r);
          pleft = pleft - 16'd1;
          if (pleft == '0) begin
            ph     = PH_FOOTER;
            idx    = '0;
            fshift = '0;
          end
        end
        PH_FOOTER: begin
          // CRC32 then ISIZE, little endian
          fshift = fshift | ({56'h0, v} << (8 * idx[2:0]));
          if (idx < FOOTER_LAST) begin
            idx++;
          end else begin
            nblk              = nblk + 17'd1;
            r.kind            = KIND_DESC;
            r.compressed_size = pay_len();
            r.uncomp_size     = fshift[63:32];
            r.out_offset      = boff;
            boff              = boff + fshift[63:32];
            r.batch_total     = boff;
            r.batch_count     = nblk;
            if (nblk >= batch_limit()) begin
              r.batch_done = 1'b1;
              nblk         = '0;
              boff         = '0;
            end
            awaited.push_back(r);
            ph     = PH_HEADER;
            idx    = '0;
            fshift = '0;
          end
        end
      endcase
    endfunction

    function void cmp(string name, logic [63:0] g, logic [63:0] w);
      if (g !== w) report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h", nres, name, g, w));
    endfunction

    // accepted result beat: compare against the oldest pending result
    function void match_result(logic [175:0] d, logic [1:0] u, logic l);
      rslt_t got, want;
      nres++;
      got.kind            = kind_t'(u);
      got.payload_byte    = d[7:0];
      got.compressed_size = d[23:8];
      got.uncomp_size     = d[55:24];
      got.out_offset      = d[103:56];
      got.batch_total     = d[151:104];
      got.batch_count     = d[168:152];
      got.batch_done      = l;
      if (awaited.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending", nres));
        return;
      end
      want = awaited.pop_front();
      cmp("kind", got.kind, want.kind);
      cmp("payload_byte", got.payload_byte, want.payload_byte);
      cmp("compressed_size", got.compressed_size, want.compressed_size);
      cmp("uncomp_size", got.uncomp_size, want.uncomp_size);
      cmp("out_offset", got.out_offset, want.out_offset);
      cmp("batch_total", got.batch_total, want.batch_total);
      cmp("batch_done", got.batch_done, want.batch_done);
      cmp("batch_count", got.batch_count, want.batch_count);
    endfunction

    function void check_drained();
      if (awaited.size() != 0) report($sformatf("%0d results never arrived", awaited.size()));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata   = '0;
  logic [0:0]         in_tuser   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [175:0]       out_tdata;
  logic [1:0]         out_tuser;
  logic               out_tlast;
  logic               cfg_we     = 1'b0;
  logic [BATCH_W-1:0] cfg_wdata  = '0;

  deframe_tracker trk;
  logic           full_rate   = 1'b0;
  int             ready_hold  = 0;
  int             beats_sent  = 0;
  int unsigned    cycle_count = 0;
  logic [7:0]     blk[$];

  logic [16:0] batch_plan [8] = '{17'd2, 17'd1, 17'd0, 17'd65536, 17'd3, 17'h1FFFF,
                                  17'd5, BATCH_RESET};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bgzf_block_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (full_rate) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result-side backpressure
  always @(posedge clk) begin
    if (full_rate) begin
      out_tready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      ready_hold = idle_len();
    end else begin
      out_tready <= 1'b1;
      ready_hold = $urandom_range(0, 8);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) trk.match_result(out_tdata, out_tuser, out_tlast);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bgzf_block_deframer_core verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic op, input logic [7:0] b);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    trk.accept_item(op, b);
    beats_sent++;
  endtask

  function automatic void add_sub(logic [7:0] a, logic [7:0] b, int len);
    blk.push_back(a);
    blk.push_back(b);
    blk.push_back(len[7:0]);
    blk.push_back(len[15:8]);
    repeat (len) blk.push_back(8'($urandom));
  endfunction

  // subfield that must not act as BSIZE, or a stale BSIZE when allowed
  function automatic void add_decoy(bit allow_stale);
    int         k, l;
    logic [7:0] a;
    k = $urandom_range(0, allow_stale ? 3 : 2);
    case (k)
      0: begin
        a = 8'($urandom);
        if (a == BSIZE_ID1) a = ~a;
        l = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 4);
        add_sub(a, 8'($urandom), l);
      end
      1: begin
        // right id, wrong length
        l = $urandom_range(0, 3);
        if (l == 2) l = 4;
        add_sub(BSIZE_ID1, BSIZE_ID2, l);
      end
      2: begin
        a = 8'($urandom);
        if (a == BSIZE_ID2) a = ~a;
        add_sub(BSIZE_ID1, a, 2);
      end
      default: add_sub(BSIZE_ID1, BSIZE_ID2, 2);
    endcase
  endfunction

  // build one block and send it; a cut block stops early and is flushed
  task automatic emit_block(input int mode, input int pay, input logic [31:0] isz,
                            input int decoys, input bit cut);
    int         xl, bs, bpos, n, l, drop, stop;
    bit         huge;
    logic [7:0] a;
    huge = (mode == MODE_NO_BSIZE || mode == MODE_WRAP || mode == MODE_WRAP_MAX);
    bpos = -1;
    blk.delete();
    if ($urandom_range(0, 3) == 0) begin
      repeat (10) blk.push_back(8'($urandom));
    end else begin
      blk.push_back(GZ_ID1);
      blk.push_back(GZ_ID2);
      blk.push_back(GZ_CM_DEFLATE);
      blk.push_back(GZ_FLG_EXTRA);
      repeat (6) blk.push_back(8'($urandom));
    end
    blk.push_back(8'h00);
    blk.push_back(8'h00);
    n = (decoys < 0) ? $urandom_range(0, 2) : decoys;
    repeat (n) add_decoy(mode != MODE_NO_BSIZE);
    if (mode != MODE_NO_BSIZE) begin
      bpos = blk.size() + 4;
      add_sub(BSIZE_ID1, BSIZE_ID2, 2);
    end
    case (mode)
      MODE_GOOD: begin
        if ($urandom_range(0, 2) == 0) add_decoy(1'b0);
      end
      MODE_CUT_LOW: void'(blk.pop_back());
      MODE_CUT_OTHER: begin
        l = $urandom_range(1, 6);
        a = 8'($urandom);
        if (a == BSIZE_ID1) a = ~a;
        add_sub(a, 8'($urandom), l);
        drop = $urandom_range(1, l + 3);
        repeat (drop) void'(blk.pop_back());
      end
      default: ;
    endcase
    // patch XLEN and the BSIZE value
    xl = blk.size() - HDR_BYTES;
    blk[XLEN_LO_AT] = xl[7:0];
    blk[XLEN_HI_AT] = xl[15:8];
    if (bpos >= 0) begin
      if (mode == MODE_WRAP_MAX) bs = xl + BSIZE_BIAS - 1;
      else if (mode == MODE_WRAP) bs = $urandom_range(0, xl + BSIZE_BIAS - 1);
      else bs = pay + xl + BSIZE_BIAS;
      blk[bpos] = bs[7:0];
      if (mode == MODE_CUT_LOW) cut = cut | (bs > 255);
      else blk[bpos + 1] = bs[15:8];
    end
    repeat (pay) blk.push_back(8'($urandom));
    if (!huge) begin
      repeat (4) blk.push_back(8'($urandom));
      for (int i = 0; i < 4; i++) blk.push_back(isz[8 * i +: 8]);
    end
    if (huge) stop = $urandom_range(blk.size() - pay + 1, blk.size());
    else if (cut) stop = $urandom_range(1, blk.size());
    else stop = blk.size();
    for (int i = 0; i < stop; i++) send_beat(OP_BYTE, blk[i]);
    if (huge || cut) send_beat(OP_FLUSH, 8'($urandom));
  endtask

  task automatic random_phase();
    int target, r, pay;
    target = beats_sent + PHASE_BEATS;
    while (beats_sent < target) begin
      r   = $urandom_range(0, 99);
      pay = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 12);
      if (r < 70) emit_block(MODE_GOOD, pay, $urandom, -1, 1'b0);
      else if (r < 76) emit_block(MODE_CUT_OTHER, pay, $urandom, -1, 1'b0);
      else if (r < 82) emit_block(MODE_CUT_LOW, pay % 8, $urandom, -1, 1'b0);
      else if (r < 88) emit_block(MODE_GOOD, pay, $urandom, -1, 1'b1);
      else if (r < 92) emit_block(MODE_NO_BSIZE, 40, '0, -1, 1'b1);
      else if (r < 96) emit_block(MODE_WRAP, 40, '0, -1, 1'b1);
      else begin
        // junk bytes (on some passes), then resync with a flush
        if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 30)) send_beat(OP_BYTE, 8'($urandom));
        send_beat(OP_FLUSH, 8'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (trk.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_batch(input logic [16:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    trk.blocks_per_batch = v;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    trk = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty flush, bare block, extremes, each odd subfield layout
    send_beat(OP_FLUSH, 8'h00);
    emit_block(MODE_GOOD, 0, 32'h0000_0000, 0, 1'b0);
    emit_block(MODE_GOOD, 2, 32'hFFFF_FFFF, 2, 1'b0);
    emit_block(MODE_CUT_LOW, 1, $urandom, 1, 1'b0);
    emit_block(MODE_CUT_OTHER, 1, $urandom, 0, 1'b0);
    emit_block(MODE_WRAP_MAX, 6, '0, 0, 1'b1);
    emit_block(MODE_NO_BSIZE, 4, '0, 0, 1'b1);
    emit_block(MODE_GOOD, 3, $urandom, 1, 1'b0);
    send_beat(OP_FLUSH, 8'hFF);

    random_phase();
    foreach (batch_plan[i]) begin
      write_batch(batch_plan[i]);
      full_rate <= (i % 3 == 1);
      random_phase();
    end

    wait_idle();
    trk.check_drained();
    if (trk.errors == 0) begin
      $display("bgzf_block_deframer_core verification clean");
    end else begin
      $display("bgzf_block_deframer_core verification failed");
    end
    $finish;
  end

endmodule
